// ----- rtl/core/bbrt_pkg.sv -----
// Shared types and fixed widths for the beacon router table.
// No dependencies; used by bbrt_div and best_beacon_router_table.
package bbrt_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned RSSI_W = 8;
  localparam int unsigned SMP_W  = 4;
  localparam int unsigned DIFF_W = RSSI_W + 1;

  localparam logic [1:0] SLOT_NONE = 2'd3;

  // request into the serial divider
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [RSSI_W-1:0] mag;
    logic [SMP_W-1:0]  den;
  } div_req_t;

  // answer from the serial divider
  typedef struct packed {
    logic                     done;
    logic signed [DIFF_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/core/bbrt_div.sv -----
// Restoring serial divider, one quotient bit per cycle, truncates toward zero.
// Depends on bbrt_pkg for the request and answer structs.
module bbrt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bbrt_pkg::div_req_t req,
  output bbrt_pkg::div_rsp_t rsp
);

  localparam int unsigned CW = $clog2(bbrt_pkg::RSSI_W);

  logic                            busy_r;
  logic                            done_r;
  logic                            neg_r;
  logic [CW-1:0]                   cnt_r;
  logic [bbrt_pkg::SMP_W-1:0]      rem_r;
  logic [bbrt_pkg::SMP_W-1:0]      den_r;
  logic [bbrt_pkg::RSSI_W-1:0]     dvd_r;

  logic [bbrt_pkg::SMP_W:0]        rem_sh;
  logic                            ge;
  logic [bbrt_pkg::SMP_W:0]        rem_sub;
  logic [bbrt_pkg::DIFF_W-1:0]     q_ext;

  assign rem_sh  = {rem_r, dvd_r[bbrt_pkg::RSSI_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign q_ext   = {1'b0, dvd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= req.mag;
        den_r  <= req.den;
        neg_r  <= req.neg;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[bbrt_pkg::SMP_W-1:0] : rem_sh[bbrt_pkg::SMP_W-1:0];
        dvd_r <= {dvd_r[bbrt_pkg::RSSI_W-2:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(bbrt_pkg::RSSI_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -$signed(q_ext) : $signed(q_ext);

  // partial remainder never reaches the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(req.start) |-> rem_r < den_r)
    else $error("divider remainder out of range");

  // completion only follows a running division
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a division");

  // no new start while a division runs
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("divider restarted while busy");

endmodule

// ----- rtl/core/best_beacon_router_table.sv -----
// Top level of the beacon router table: sequencer, entry storage, output word.
// Depends on bbrt_pkg and bbrt_div (shared serial divider).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | input     | in_valid / in_stall | beacon_address, beacon_rssi, beacon_tx_power
//  out_    | output    | out_valid/out_stall | taken, slot, entries_in_use, best_*
//
// Steps: one beacon takes an accept step, an address scan (one entry per cycle, up
//   to the match or over all used entries), a decide step when no entry matches, then if
//   taken a prep step, a divide step when the entry already holds a sample, and a
//   strongest-entry scan over the used entries, and a done step. The serial divider and
//   the one-entry-a-cycle table read port set how long a beacon takes.
// Reset: sequencer idle, table empty (sample counts zero), no result pending.
// Stalls: in_stall is high while a beacon is in work; a pending result waits in the
//   output register and only holds the sequencer at its last step.
module best_beacon_router_table #(
  parameter int unsigned TABLE_ENTRIES = 3,
  parameter int unsigned MAX_SAMPLES   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bbrt_pkg::ADDR_W-1:0]         in_beacon_address,
  input  logic signed [bbrt_pkg::RSSI_W-1:0]  in_beacon_rssi,
  input  logic signed [bbrt_pkg::RSSI_W-1:0]  in_beacon_tx_power,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_taken,
  output logic [1:0]                          out_slot,
  output logic [1:0]                          out_entries_in_use,
  output logic [bbrt_pkg::ADDR_W-1:0]         out_best_address,
  output logic signed [bbrt_pkg::RSSI_W-1:0]  out_best_rssi,
  output logic signed [bbrt_pkg::RSSI_W-1:0]  out_best_tx_power
);

  // index width for reads, and a wider count that also holds TABLE_ENTRIES itself
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned XW = ($clog2(TABLE_ENTRIES + 1) > 2) ?
                               $clog2(TABLE_ENTRIES + 1) : 2;
  localparam int unsigned SW = bbrt_pkg::SMP_W;
  localparam int unsigned RW = bbrt_pkg::RSSI_W;
  localparam int unsigned DW = bbrt_pkg::DIFF_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PREP,
    ST_DIV,
    ST_BEST,
    ST_DONE
  } state_t;

  state_t state_r;

  // router table; one read port addressed by idx_r
  logic [bbrt_pkg::ADDR_W-1:0] ent_addr_r [TABLE_ENTRIES];
  logic signed [RW-1:0]        ent_rssi_r [TABLE_ENTRIES];
  logic signed [RW-1:0]        ent_txp_r  [TABLE_ENTRIES];
  logic [SW-1:0]               ent_smp_r  [TABLE_ENTRIES];

  logic [XW-1:0] used_r;
  logic [XW-1:0] idx_r;
  logic [XW-1:0] tgt_r;
  logic [XW-1:0] weak_r;
  logic signed [RW-1:0] weak_rssi_r;
  logic          fresh_r;
  logic          taken_r;
  logic [SW-1:0] den_r;

  // latched beacon
  logic [bbrt_pkg::ADDR_W-1:0] bcn_addr_r;
  logic signed [RW-1:0]        bcn_rssi_r;
  logic signed [RW-1:0]        bcn_txp_r;

  // strongest entry, kept across beacons
  logic [bbrt_pkg::ADDR_W-1:0] best_addr_r;
  logic signed [RW-1:0]        best_rssi_r;
  logic signed [RW-1:0]        best_txp_r;

  logic                        out_valid_r;
  logic                        out_taken_r;
  logic [1:0]                  out_slot_r;
  logic [1:0]                  out_used_r;
  logic [bbrt_pkg::ADDR_W-1:0] out_addr_r;
  logic signed [RW-1:0]        out_rssi_r;
  logic signed [RW-1:0]        out_txp_r;

  // read port
  logic [IW-1:0]               ri;
  logic [bbrt_pkg::ADDR_W-1:0] rd_addr;
  logic signed [RW-1:0]        rd_rssi;
  logic [SW-1:0]               rd_smp;

  logic [XW-1:0]        used_m1;
  logic                 full;
  logic [SW-1:0]        smp_cur;
  logic [SW-1:0]        smp_new;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        diff_mag;
  logic signed [DW:0]   rssi_sum;
  logic                 out_free;

  bbrt_pkg::div_req_t div_req;
  bbrt_pkg::div_rsp_t div_rsp;

  assign ri      = idx_r[IW-1:0];
  assign rd_addr = ent_addr_r[ri];
  assign rd_rssi = ent_rssi_r[ri];
  assign rd_smp  = ent_smp_r[ri];

  assign used_m1 = used_r - XW'(1);
  assign full    = used_r == XW'(TABLE_ENTRIES);

  // sample count after this beacon, saturating; a new or replaced entry starts over
  assign smp_cur = fresh_r ? '0 : rd_smp;
  assign smp_new = (smp_cur < SW'(MAX_SAMPLES)) ? smp_cur + SW'(1) : smp_cur;

  assign diff     = DW'(bcn_rssi_r) - DW'(rd_rssi);
  assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign rssi_sum = (DW+1)'(rd_rssi) + (DW+1)'(div_rsp.quot);

  assign div_req.start = (state_r == ST_PREP) && (smp_new > SW'(1));
  assign div_req.neg   = diff[DW-1];
  assign div_req.mag   = diff_mag[RW-1:0];
  assign div_req.den   = smp_new;

  assign out_free = !out_valid_r || !out_stall;

  bbrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sample counts: reset to zero, written when an entry takes a beacon
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        ent_smp_r[k] <= '0;
      end
    end else if (state_r == ST_PREP) begin
      ent_smp_r[ri] <= smp_new;
    end
  end

  // address, rssi and tx power: no reset, only entries below used_r are read
  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      ent_addr_r[ri] <= bcn_addr_r;
      ent_txp_r[ri]  <= bcn_txp_r;
      if (!div_req.start) begin
        ent_rssi_r[ri] <= bcn_rssi_r;
      end
    end else if (state_r == ST_DIV && div_rsp.done) begin
      ent_rssi_r[ri] <= rssi_sum[RW-1:0];
    end
  end

  // sequencer and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the done step reloads the output word itself
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            bcn_addr_r <= in_beacon_address;
            bcn_rssi_r <= in_beacon_rssi;
            bcn_txp_r  <= in_beacon_tx_power;
            idx_r      <= '0;
            state_r    <= (used_r == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_addr == bcn_addr_r) begin
            // known router: idx_r already points at it
            fresh_r <= 1'b0;
            state_r <= ST_PREP;
          end else begin
            if (idx_r == '0 || rd_rssi < weak_rssi_r) begin
              weak_r      <= idx_r;
              weak_rssi_r <= rd_rssi;
            end
            if (idx_r == used_m1) begin
              state_r <= ST_DECIDE;
            end else begin
              idx_r <= idx_r + XW'(1);
            end
          end
        end
        ST_DECIDE: begin
          fresh_r <= 1'b1;
          if (!full) begin
            idx_r   <= used_r;
            used_r  <= used_r + XW'(1);
            state_r <= ST_PREP;
          end else if (bcn_rssi_r > weak_rssi_r) begin
            idx_r   <= weak_r;
            state_r <= ST_PREP;
          end else begin
            taken_r <= 1'b0;
            state_r <= ST_DONE;
          end
        end
        ST_PREP: begin
          tgt_r   <= idx_r;
          taken_r <= 1'b1;
          den_r   <= smp_new;
          if (div_req.start) begin
            state_r <= ST_DIV;
          end else begin
            idx_r   <= '0;
            state_r <= ST_BEST;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            idx_r   <= '0;
            state_r <= ST_BEST;
          end
        end
        ST_BEST: begin
          // highest rssi wins, lowest index on ties
          if (idx_r == '0 || rd_rssi > best_rssi_r) begin
            best_addr_r <= rd_addr;
            best_rssi_r <= rd_rssi;
            best_txp_r  <= ent_txp_r[ri];
          end
          if (idx_r == used_m1) begin
            state_r <= ST_DONE;
          end else begin
            idx_r <= idx_r + XW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_taken_r <= taken_r;
            out_slot_r  <= taken_r ? tgt_r[1:0] : bbrt_pkg::SLOT_NONE;
            out_used_r  <= used_r[1:0];
            out_addr_r  <= best_addr_r;
            out_rssi_r  <= best_rssi_r;
            out_txp_r   <= best_txp_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall           = state_r != ST_IDLE;
  assign out_valid          = out_valid_r;
  assign out_taken          = out_taken_r;
  assign out_slot           = out_slot_r;
  assign out_entries_in_use = out_used_r;
  assign out_best_address   = out_addr_r;
  assign out_best_rssi      = out_rssi_r;
  assign out_best_tx_power  = out_txp_r;

  // table never holds more routers than it has slots
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= XW'(TABLE_ENTRIES))
    else $error("used count beyond table size");

  // the filter only divides once an entry has two or more samples
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> den_r > SW'(1))
    else $error("divide with fewer than two samples");

  // a new result word is only produced at the end of the sequence
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word outside done step");

  // reads stay inside the table while scanning
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_BEST) |-> idx_r < used_r)
    else $error("scan index past used entries");

endmodule

// ----- test/router_table_checker.sv -----
`timescale 1ns / 100ps
// Checker for best_beacon_router_table: watches both channels, predicts each result word
// from its own copy of the router table and compares it field by field. Uses bbrt_pkg.
module router_table_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [bbrt_pkg::ADDR_W-1:0]         in_beacon_address,
  input  logic signed [bbrt_pkg::RSSI_W-1:0]  in_beacon_rssi,
  input  logic signed [bbrt_pkg::RSSI_W-1:0]  in_beacon_tx_power,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_taken,
  input  logic [1:0]                          out_slot,
  input  logic [1:0]                          out_entries_in_use,
  input  logic [bbrt_pkg::ADDR_W-1:0]         out_best_address,
  input  logic signed [bbrt_pkg::RSSI_W-1:0]  out_best_rssi,
  input  logic signed [bbrt_pkg::RSSI_W-1:0]  out_best_tx_power,
  output int                                  fail_count,
  output int                                  words_pending,
  output int                                  words_checked
);

  localparam int ROUTERS     = 3;
  localparam int MAX_SAMPLES = 8;

  typedef struct packed {
    logic                        taken;
    logic [1:0]                  slot;
    logic [1:0]                  entries_in_use;
    logic [bbrt_pkg::ADDR_W-1:0] best_address;
    logic [bbrt_pkg::RSSI_W-1:0] best_rssi;
    logic [bbrt_pkg::RSSI_W-1:0] best_tx_power;
  } table_status_t;

  // predicted router table
  logic [bbrt_pkg::ADDR_W-1:0] rt_addr [ROUTERS];
  int                          rt_rssi [ROUTERS];
  logic [bbrt_pkg::RSSI_W-1:0] rt_txp [ROUTERS];
  int                          rt_samples [ROUTERS];
  int                          rt_used;
  int                          rt_best;

  table_status_t expected_status_q [$];
  int            mismatches = 0;
  int            checked = 0;

  assign fail_count = mismatches;

  function automatic table_status_t route_beacon(logic [bbrt_pkg::ADDR_W-1:0] addr,
                                                 logic signed [bbrt_pkg::RSSI_W-1:0] rssi,
                                                 logic signed [bbrt_pkg::RSSI_W-1:0] txp);
    int            hit;
    int            weakest;
    int            n;
    table_status_t s;
    hit = ROUTERS;
    for (int k = 0; k < rt_used; k++)
      if (hit == ROUTERS && rt_addr[k] == addr) hit = k;
    if (hit == ROUTERS) begin
      if (rt_used >= ROUTERS) begin
        weakest = 0;
        for (int k = 1; k < ROUTERS; k++)
          if (rt_rssi[k] < rt_rssi[weakest]) weakest = k;
        // full table: only a strictly stronger newcomer evicts the weakest
        if (int'(rssi) > rt_rssi[weakest]) begin
          hit = weakest;
          rt_samples[hit] = 0;
          rt_rssi[hit] = 0;
        end
      end else begin
        hit = rt_used;
        rt_used++;
      end
    end
    s.taken = (hit < ROUTERS);
    if (s.taken) begin
      if (rt_samples[hit] < MAX_SAMPLES) rt_samples[hit]++;
      n = rt_samples[hit];
      rt_addr[hit] = addr;
      rt_txp[hit] = txp;
      // int division truncates toward zero
      if (n > 1) rt_rssi[hit] = rt_rssi[hit] + (int'(rssi) - rt_rssi[hit]) / n;
      else rt_rssi[hit] = int'(rssi);
      rt_best = 0;
      for (int k = 1; k < rt_used; k++)
        if (rt_rssi[k] > rt_rssi[rt_best]) rt_best = k;
    end
    s.slot = s.taken ? hit[1:0] : bbrt_pkg::SLOT_NONE;
    s.entries_in_use = rt_used[1:0];
    s.best_address = rt_addr[rt_best];
    s.best_rssi = rt_rssi[rt_best][bbrt_pkg::RSSI_W-1:0];
    s.best_tx_power = rt_txp[rt_best];
    return s;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    table_status_t want;
    if (!rst_n) begin
      for (int k = 0; k < ROUTERS; k++) begin
        rt_addr[k] = '0;
        rt_rssi[k] = 0;
        rt_txp[k] = '0;
        rt_samples[k] = 0;
      end
      rt_used = 0;
      rt_best = 0;
      expected_status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_status_q.size() == 0) begin
          $display("%0t ns: result word with no beacon outstanding", $time);
          mismatches++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("taken", 32'(want.taken), 32'(out_taken));
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("entries_in_use", 32'(want.entries_in_use), 32'(out_entries_in_use));
          check_field("best_address", want.best_address, out_best_address);
          check_field("best_rssi", 32'(want.best_rssi), 32'($unsigned(out_best_rssi)));
          check_field("best_tx_power", 32'(want.best_tx_power),
                      32'($unsigned(out_best_tx_power)));
        end
      end
      if (in_valid && !in_stall)
        expected_status_q.push_back(route_beacon(in_beacon_address, in_beacon_rssi,
                                                 in_beacon_tx_power));
    end
    words_pending <= expected_status_q.size();
    words_checked <= checked;
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Top of the router table testbench: clock, reset, beacon stimulus, result-side stalls
// and the verdict. Depends on bbrt_pkg, best_beacon_router_table and router_table_checker.
module testbench;

  // run limit allows for the slowest beacon, long gaps, stalls and the receiver hold
  localparam int CYCLE_LIMIT    = 500000;
  localparam int RANDOM_BEACONS = 1050;
  localparam int POOL_SIZE      = 4;     // more addresses than table rows forces evictions
  localparam int LONG_HOLD      = 500;   // receiver hold that backs the block up
  localparam int DRAIN_CYCLES   = 40;    // quiet time after the drain, longer than the slowest beacon

  logic clk = 1'b0;
  logic rst_n;

  logic                                in_valid;
  logic                                in_stall;
  logic [bbrt_pkg::ADDR_W-1:0]         in_beacon_address;
  logic signed [bbrt_pkg::RSSI_W-1:0]  in_beacon_rssi;
  logic signed [bbrt_pkg::RSSI_W-1:0]  in_beacon_tx_power;
  logic                                out_valid;
  logic                                out_stall;
  logic                                out_taken;
  logic [1:0]                          out_slot;
  logic [1:0]                          out_entries_in_use;
  logic [bbrt_pkg::ADDR_W-1:0]         out_best_address;
  logic signed [bbrt_pkg::RSSI_W-1:0]  out_best_rssi;
  logic signed [bbrt_pkg::RSSI_W-1:0]  out_best_tx_power;

  int fail_count;
  int words_pending;
  int words_checked;
  int cycle_count = 0;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  best_beacon_router_table u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_beacon_address  (in_beacon_address),
    .in_beacon_rssi     (in_beacon_rssi),
    .in_beacon_tx_power (in_beacon_tx_power),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_taken          (out_taken),
    .out_slot           (out_slot),
    .out_entries_in_use (out_entries_in_use),
    .out_best_address   (out_best_address),
    .out_best_rssi      (out_best_rssi),
    .out_best_tx_power  (out_best_tx_power)
  );

  router_table_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_beacon_address  (in_beacon_address),
    .in_beacon_rssi     (in_beacon_rssi),
    .in_beacon_tx_power (in_beacon_tx_power),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_taken          (out_taken),
    .out_slot           (out_slot),
    .out_entries_in_use (out_entries_in_use),
    .out_best_address   (out_best_address),
    .out_best_rssi      (out_best_rssi),
    .out_best_tx_power  (out_best_tx_power),
    .fail_count         (fail_count),
    .words_pending      (words_pending),
    .words_checked      (words_checked)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beacon and hold it until the block takes it. Called just after a rising
  // edge; in_stall read here is the value the edge saw, since the block updates it
  // with nonblocking assignments.
  task automatic send_beacon(logic [bbrt_pkg::ADDR_W-1:0] addr,
                             logic signed [bbrt_pkg::RSSI_W-1:0] rssi,
                             logic signed [bbrt_pkg::RSSI_W-1:0] txp);
    in_valid           <= 1'b1;
    in_beacon_address  <= addr;
    in_beacon_rssi     <= rssi;
    in_beacon_tx_power <= txp;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid between words for the given gap; n == 0 keeps valid high into the next word.
  task automatic sender_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender goes quiet until every expected result word has been checked. The first
  // edge lets words_pending pick up a word accepted at the current edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // Run limit; a hung handshake or a lost result word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stall bursts, occasional calm stretches, and one long hold
  // once a few hundred words have gone by so the block backs up and stalls its input.
  initial begin : receiver
    int  stall_len;
    int  free_len;
    bit  hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!hold_done && words_checked >= 400) begin
        stall_len = LONG_HOLD;
        hold_done = 1'b1;
      end else begin
        stall_len = pick_gap();
      end
      free_len = ($urandom_range(0, 99) < 3) ? $urandom_range(100, 200)
                                             : $urandom_range(1, 4);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [bbrt_pkg::ADDR_W-1:0]        pool [POOL_SIZE];
    logic [bbrt_pkg::ADDR_W-1:0]        addr;
    logic signed [bbrt_pkg::RSSI_W-1:0] rssi;
    logic signed [bbrt_pkg::RSSI_W-1:0] rssi_corner [4];

    rssi_corner[0] = -8'sd128;
    rssi_corner[1] = 8'sd127;
    rssi_corner[2] = -8'sd1;
    rssi_corner[3] = 8'sd0;

    in_valid           <= 1'b0;
    in_beacon_address  <= '0;
    in_beacon_rssi     <= '0;
    in_beacon_tx_power <= '0;
    rst_n              <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // first beacon into an empty table, all fields at their low extreme
    send_beacon(32'h0000_0000, -8'sd128, -8'sd128);
    // same router again: filter over two samples, high extremes
    send_beacon(32'h0000_0000, 8'sd127, 8'sd127);
    // second and third routers tie the first on RSSI: best stays at the lowest slot
    send_beacon(32'hFFFF_FFFF, -8'sd1, 8'sd0);
    send_beacon(32'h5A5A_5A5A, -8'sd1, 8'sd1);
    // table full, newcomer only equal to the weakest: dropped
    send_beacon(32'h1234_5678, -8'sd1, 8'sd5);
    // strictly stronger newcomer evicts the weakest, lowest slot on a three-way tie
    send_beacon(32'h1234_5678, 8'sd0, 8'sd5);
    // run one router up to the sample limit, then pull it down past the limit so the
    // filter truncates a negative step
    repeat (7) send_beacon(32'hFFFF_FFFF, 8'sd127, -8'sd2);
    repeat (2) send_beacon(32'hFFFF_FFFF, -8'sd128, 8'sd3);
    send_beacon(32'h5A5A_5A5A, -8'sd128, -8'sd128);
    // equal to the weakest again (dropped), then one above it (replaces it)
    send_beacon(32'h8765_4321, -8'sd64, 8'sd3);
    send_beacon(32'h8765_4321, -8'sd63, 8'sd3);
    // an evicted address comes back as a newcomer
    send_beacon(32'h0000_0000, 8'sd127, 8'sd127);
    send_beacon(32'h1234_5678, 8'sd127, -8'sd1);
    wait_drained();

    // --- random part ---
    // Most beacons come from a small address pool so routers recur, get filtered and
    // fight over the three rows; the rest are fresh addresses.
    for (int i = 0; i < RANDOM_BEACONS; i++) begin
      if (i % 120 == 0)
        for (int p = 0; p < POOL_SIZE; p++)
          pool[p] = ($urandom_range(0, 9) == 0) ? {32{p[0]}} : $urandom;
      // sender pause until the block has given back everything
      if (i % 300 == 299) wait_drained();
      addr = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
      // corner values make ties for best and weakest likely
      rssi = ($urandom_range(0, 4) == 0) ? rssi_corner[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, 255));
      send_beacon(addr, rssi, 8'($urandom_range(0, 255)));
      // a back-to-back stretch with no sender idling
      if (i < 600 || i >= 700) sender_gap(pick_gap());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
